[sv/mcpt_pkg.sv]
package mcpt_pkg;

    localparam int DATA_W       = 32;
    localparam int CH_W         = 2;
    localparam int OP_W         = 2;
    localparam int SLOTS_W      = 13;
    localparam int TMO_W        = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;
    localparam int CHANNELS_DEF = 4;
    localparam int MAX_REPORTED = 4;

    localparam logic [SLOTS_W-1:0] SLOTS_RST = SLOTS_W'(20);
    localparam logic [TMO_W-1:0]   TMO_RST   = TMO_W'(500);

    // rpm in Q8: pulses * 60000 * 256 / (elapsed_ms * slots)
    localparam int MS_PER_MIN = 60000;
    localparam int SCALE_W    = 24;
    localparam logic [SCALE_W-1:0] RPM_SCALE = SCALE_W'(MS_PER_MIN * 256);

    localparam int DIV_NUM_W = DATA_W + SCALE_W;
    localparam int DIV_DEN_W = TMO_W + SLOTS_W;
    localparam int DIV_Q_W   = DATA_W;

    typedef enum logic [OP_W-1:0] {
        OP_PULSE  = 2'd0,
        OP_UPDATE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOTS   = 1'b0,
        CFG_TIMEOUT = 1'b1
    } t_cfg_idx;

endpackage

[sv/mcpt_in_if.sv]
interface mcpt_in_if import mcpt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [CH_W-1:0]   channel;
    logic [DATA_W-1:0] now_ms;

    modport source (output valid, output op, output channel, output now_ms, input ready);
    modport sink   (input valid, input op, input channel, input now_ms, output ready);
endinterface

[sv/mcpt_out_if.sv]
interface mcpt_out_if import mcpt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   result_channel;
    logic [DATA_W-1:0] pulse_total;
    logic [DATA_W-1:0] rpm_q8;
    logic              last;

    modport source (output valid, output result_channel, output pulse_total,
                    output rpm_q8, output last, input ready);
    modport sink   (input valid, input result_channel, input pulse_total,
                    input rpm_q8, input last, output ready);
endinterface

[sv/mcpt_div.sv]
module mcpt_div import mcpt_pkg::*; #(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = DIV_DEN_W,
    parameter int Q_W   = DIV_Q_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quot
);

    localparam int HI_W  = NUM_W - Q_W;
    localparam int CNT_W = $clog2(Q_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [Q_W-1:0]   r_q;

    logic [HI_W-1:0]  w_hi;
    logic             w_ovf;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    // quotient >= 2^Q_W exactly when the upper numerator part is >= den
    assign w_hi    = i_num[NUM_W-1:Q_W];
    assign w_ovf   = (w_hi >= i_den);
    assign w_trial = {r_rem, r_q[Q_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= !w_ovf;
                r_done <= w_ovf;
                r_cnt  <= CNT_W'(Q_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle; quotient bits shift
    // in at the bottom as numerator bits leave at the top
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= DEN_W'(w_hi);
            r_q   <= w_ovf ? '1 : i_num[Q_W-1:0];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_q   <= {r_q[Q_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[sv/multi_channel_pulse_tachometer.sv]
// Pulse-counting tachometer for CHANNELS channels. Each input transfer is
// one operation: pulse (count one edge), clear (zero a channel's count,
// sample and rpm), read (one result) or update (sample every channel at
// now_ms and give one result per channel below REPORTED, at most four, last on the final one).
// Speed is pulses*60000/(elapsed_ms*slots_per_rev) in unsigned Q24.8,
// truncated and saturated; it holds when no time has elapsed and drops to
// zero once elapsed exceeds stop_timeout_ms. Pulse and clear complete at
// the transfer; a read passes through the result stage. An update runs
// each channel in turn, dividing on the shared bit-serial divider, which
// produces one quotient bit per cycle; saturated, held and timed-out
// channels finish sooner. Input ready is high only while the sequencer is
// idle; a finished result waits in the output register meanwhile.
module multi_channel_pulse_tachometer import mcpt_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mcpt_in_if.sink               i_in,
    mcpt_out_if.source            o_res
);

    localparam int IW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int REPORTED = (CHANNELS < MAX_REPORTED) ? CHANNELS : MAX_REPORTED;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIFF  = 6'b000010,
        S_MUL   = 6'b000100,
        S_START = 6'b001000,
        S_DIV   = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        MODE_KEEP = 2'd0,
        MODE_ZERO = 2'd1,
        MODE_DIV  = 2'd2
    } t_mode;

    t_state r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    t_mode r_mode;

    logic [SLOTS_W-1:0] r_slots;
    logic [TMO_W-1:0]   r_tmo;

    logic [DATA_W-1:0] r_cnt   [CHANNELS];
    logic [DATA_W-1:0] r_samp  [CHANNELS];
    logic [DATA_W-1:0] r_time  [CHANNELS];
    logic [DATA_W-1:0] r_speed [CHANNELS];

    logic [DATA_W-1:0]    r_now;
    logic [DATA_W-1:0]    r_pulses;
    logic [TMO_W-1:0]     r_el;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    logic                 r_is_read;
    logic                 r_rd_absent;
    logic [CH_W-1:0]      r_rd_ch;

    logic              r_out_valid;
    logic [CH_W-1:0]   r_out_ch;
    logic [DATA_W-1:0] r_out_tot;
    logic [DATA_W-1:0] r_out_rpm;
    logic              r_out_last;

    logic              w_in_xfer;
    t_op               w_op;
    logic              w_present;
    logic [IW-1:0]     w_in_idx;
    logic [IW-1:0]     w_cnt_addr;
    logic [DATA_W-1:0] w_cnt_rd;
    logic [DATA_W-1:0] w_spd_rd;
    logic [DATA_W-1:0] w_elapsed;
    logic [SLOTS_W-1:0] w_slots;
    logic              w_out_free;
    logic              w_report;
    logic              w_div_start;
    logic              w_div_done;
    logic [DIV_Q_W-1:0] w_quot;

    logic              cnt_inc;
    logic              clr;
    logic              samp_we;
    logic              spd_we;
    logic [DATA_W-1:0] spd_val;
    logic              out_load;
    logic [CH_W-1:0]   out_ch;
    logic [DATA_W-1:0] out_tot;
    logic [DATA_W-1:0] out_rpm;
    logic              out_last;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_op       = t_op'(i_in.op);
    assign w_present  = (5'(i_in.channel) < 5'(CHANNELS));
    assign w_in_idx   = IW'(i_in.channel);

    // single count read port: input channel while idle, sequencer otherwise
    assign w_cnt_addr = (r_state == S_IDLE) ? w_in_idx : r_idx;
    assign w_cnt_rd   = r_cnt[w_cnt_addr];
    assign w_spd_rd   = r_speed[r_idx];
    assign w_elapsed  = r_now - r_time[r_idx];
    assign w_slots    = (r_slots == '0) ? SLOTS_W'(1) : r_slots;
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_report   = (5'(r_idx) < 5'(REPORTED));
    assign w_div_start = (r_state == S_START) && (r_mode == MODE_DIV);

    mcpt_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W),
        .Q_W   (DIV_Q_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        cnt_inc  = 1'b0;
        clr      = 1'b0;
        samp_we  = 1'b0;
        spd_we   = 1'b0;
        spd_val  = '0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    case (w_op)
                        OP_PULSE:  cnt_inc = w_present;
                        OP_CLEAR:  clr = w_present;
                        OP_UPDATE: begin
                            n_idx   = '0;
                            n_state = S_DIFF;
                        end
                        OP_READ: begin
                            n_idx   = w_in_idx;
                            n_state = S_EMIT;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIFF: begin
                samp_we = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: n_state = S_START;
            S_START: begin
                case (r_mode)
                    MODE_KEEP: n_state = S_EMIT;
                    MODE_ZERO: begin
                        spd_we  = 1'b1;
                        n_state = S_EMIT;
                    end
                    default: n_state = S_DIV;
                endcase
            end
            S_DIV: begin
                if (w_div_done) begin
                    spd_we  = 1'b1;
                    spd_val = w_quot;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (r_is_read) begin
                    if (w_out_free) begin
                        out_load = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else if (!w_report || w_out_free) begin
                    out_load = w_report;
                    if (r_idx == IW'(CHANNELS - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_DIFF;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (r_is_read) begin
            out_ch   = r_rd_ch;
            out_tot  = r_rd_absent ? '0 : w_cnt_rd;
            out_rpm  = r_rd_absent ? '0 : w_spd_rd;
            out_last = 1'b1;
        end else begin
            out_ch   = CH_W'(r_idx);
            out_tot  = w_cnt_rd;
            out_rpm  = w_spd_rd;
            out_last = (5'(r_idx) == 5'(REPORTED - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_mode      <= MODE_KEEP;
            r_is_read   <= 1'b0;
            r_out_valid <= 1'b0;
            r_slots     <= SLOTS_RST;
            r_tmo       <= TMO_RST;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (w_in_xfer) begin
                r_is_read <= (w_op == OP_READ);
            end
            if (r_state == S_DIFF) begin
                if (w_elapsed == '0) begin
                    r_mode <= MODE_KEEP;
                end else if (w_elapsed > DATA_W'(r_tmo)) begin
                    r_mode <= MODE_ZERO;
                end else begin
                    r_mode <= MODE_DIV;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SLOTS:   r_slots <= i_cfg_data[SLOTS_W-1:0];
                    CFG_TIMEOUT: r_tmo <= i_cfg_data[TMO_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_cnt[i]   <= '0;
                r_samp[i]  <= '0;
                r_time[i]  <= '0;
                r_speed[i] <= '0;
            end
        end else begin
            for (int i = 0; i < CHANNELS; i++) begin
                if (cnt_inc && w_in_idx == IW'(i)) begin
                    r_cnt[i] <= w_cnt_rd + 1'b1;
                end
                if (clr && w_in_idx == IW'(i)) begin
                    r_cnt[i]   <= '0;
                    r_samp[i]  <= '0;
                    r_speed[i] <= '0;
                end
                if (samp_we && r_idx == IW'(i)) begin
                    r_samp[i] <= w_cnt_rd;
                    r_time[i] <= r_now;
                end
                if (spd_we && r_idx == IW'(i)) begin
                    r_speed[i] <= spd_val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_now       <= i_in.now_ms;
            r_rd_ch     <= i_in.channel;
            r_rd_absent <= !w_present;
        end
        if (r_state == S_DIFF) begin
            r_pulses <= w_cnt_rd - r_samp[r_idx];
            r_el     <= w_elapsed[TMO_W-1:0];
        end
        if (r_state == S_MUL) begin
            r_num <= DIV_NUM_W'(r_pulses) * DIV_NUM_W'(RPM_SCALE);
            r_den <= DIV_DEN_W'(r_el) * DIV_DEN_W'(w_slots);
        end
        if (out_load) begin
            r_out_ch   <= out_ch;
            r_out_tot  <= out_tot;
            r_out_rpm  <= out_rpm;
            r_out_last <= out_last;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.result_channel = r_out_ch;
    assign o_res.pulse_total    = r_out_tot;
    assign o_res.rpm_q8         = r_out_rpm;
    assign o_res.last           = r_out_last;

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    a_read_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && w_op == OP_READ |=> r_state == S_EMIT && r_is_read)
        else $error("read transfer did not go to result stage");

    a_update_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && w_op == OP_UPDATE |=> r_state == S_DIFF && r_idx == '0)
        else $error("update sweep did not start at channel zero");

endmodule

[tb/tb.sv]
module tb;
    import mcpt_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 200;
    localparam int REPORTED     = (CHANNELS_DEF < MAX_REPORTED) ? CHANNELS_DEF : MAX_REPORTED;

    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic [DATA_W-1:0] total;
        logic [DATA_W-1:0] rpm;
        logic              last;
    } t_reading;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mcpt_in_if  in_if ();
    mcpt_out_if res_if ();

    multi_channel_pulse_tachometer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_res      (res_if)
    );

    // shadow of the tachometer state
    logic [DATA_W-1:0]  count_m    [CHANNELS_DEF];
    logic [DATA_W-1:0]  snap_cnt_m [CHANNELS_DEF];
    logic [DATA_W-1:0]  snap_ms_m  [CHANNELS_DEF];
    logic [DATA_W-1:0]  rpm_m      [CHANNELS_DEF];
    logic [SLOTS_W-1:0] slots_m;
    logic [TMO_W-1:0]   tmo_m;

    t_reading readings_q[$];
    int       mismatch_cnt = 0;
    int       xfer_cnt     = 0;
    bit       quiet        = 1'b0;
    bit       hold_req     = 1'b0;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic logic [DATA_W-1:0] rpm_from(logic [DATA_W-1:0] pulses,
                                                   logic [DATA_W-1:0] elapsed);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        num = 64'(pulses) * 64'(MS_PER_MIN) * 64'd256;
        den = 64'(elapsed) * ((slots_m == '0) ? 64'd1 : 64'(slots_m));
        quo = num / den;
        return (quo > 64'hFFFF_FFFF) ? '1 : quo[DATA_W-1:0];
    endfunction

    function automatic void apply_op(t_op op, logic [CH_W-1:0] ch, logic [DATA_W-1:0] now);
        logic [DATA_W-1:0] pulses;
        logic [DATA_W-1:0] elapsed;
        case (op)
            OP_PULSE: count_m[ch] = count_m[ch] + 1'b1;
            OP_CLEAR: begin
                count_m[ch]    = '0;
                snap_cnt_m[ch] = '0;
                rpm_m[ch]      = '0;
            end
            OP_READ: readings_q.push_back('{ch, count_m[ch], rpm_m[ch], 1'b1});
            OP_UPDATE: begin
                for (int i = 0; i < CHANNELS_DEF; i++) begin
                    pulses  = count_m[i] - snap_cnt_m[i];
                    elapsed = now - snap_ms_m[i];
                    if (elapsed != '0) rpm_m[i] = rpm_from(pulses, elapsed);
                    // stopped shaft: too long since the last sample
                    if (elapsed > DATA_W'(tmo_m)) rpm_m[i] = '0;
                    snap_cnt_m[i] = count_m[i];
                    snap_ms_m[i]  = now;
                    if (i < REPORTED)
                        readings_q.push_back('{CH_W'(i), count_m[i], rpm_m[i],
                                               1'(i == REPORTED - 1)});
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_op(t_op op, logic [CH_W-1:0] ch, logic [DATA_W-1:0] now);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.op      <= op;
        in_if.channel <= ch;
        in_if.now_ms  <= now;
        do @(posedge i_clk); while (!in_if.ready);
        apply_op(op, ch, now);
        xfer_cnt++;
    endtask

    // block must be idle before a register write
    task automatic settle();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (readings_q.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_config(logic [SLOTS_W-1:0] slots, logic [TMO_W-1:0] tmo);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SLOTS;
        i_cfg_data <= CFG_DATA_W'(slots);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TIMEOUT;
        i_cfg_data <= tmo;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        slots_m = slots;
        tmo_m   = tmo;
    endtask

    function automatic logic [DATA_W-1:0] next_gap();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) return $urandom_range(1, 100);
        if (pick == 7) return '0;
        if (pick == 8) return DATA_W'(tmo_m) + $urandom_range(0, 1);
        return $urandom_range(1, 70000);
    endfunction

    // mostly pulse bursts closed by an update, with clears, reads and noise mixed in
    task automatic drive_traffic(int n);
        int stop_at;
        int pick;
        stop_at = xfer_cnt + n;
        while (xfer_cnt < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick <= 6) begin
                repeat ($urandom_range(0, 12)) send_op(OP_PULSE, CH_W'($urandom), $urandom);
                if ($urandom_range(0, 2) == 0) send_op(OP_READ, CH_W'($urandom), $urandom);
                send_op(OP_UPDATE, CH_W'($urandom), snap_ms_m[0] + next_gap());
            end else if (pick == 7) begin
                send_op(OP_CLEAR, CH_W'($urandom), $urandom);
            end else if (pick == 8) begin
                send_op(OP_READ, CH_W'($urandom), $urandom);
            end else begin
                send_op(t_op'($urandom_range(0, 3)), CH_W'($urandom), $urandom);
            end
        end
    endtask

    task automatic test_reset_state();
        for (int i = 0; i < CHANNELS_DEF; i++) send_op(OP_READ, CH_W'(i), '0);
        send_op(OP_UPDATE, 2'd0, '0);
    endtask

    task automatic test_directed_ops();
        repeat (3) send_op(OP_PULSE, 2'd0, '0);
        send_op(OP_PULSE, 2'd1, '1);
        repeat (2) send_op(OP_PULSE, 2'd3, '0);
        send_op(OP_UPDATE, 2'd0, 32'd100);
        send_op(OP_READ, 2'd0, '0);
        send_op(OP_UPDATE, 2'd3, 32'd100);         // no time elapsed: speed held
        send_op(OP_CLEAR, 2'd1, '0);
        send_op(OP_READ, 2'd1, '0);
        send_op(OP_PULSE, 2'd2, '0);
        send_op(OP_UPDATE, 2'd0, 32'd600);         // elapsed equals timeout
        send_op(OP_UPDATE, 2'd0, 32'd1101);        // one past timeout
        send_op(OP_READ, 2'd3, '0);
        send_op(OP_UPDATE, 2'd2, 32'hFFFF_FF00);
        repeat (2) send_op(OP_PULSE, 2'd0, '0);
        send_op(OP_UPDATE, 2'd1, 32'h0000_0010);   // time wraps
    endtask

    task automatic test_register_extremes();
        set_config(13'd0, 16'd65535);              // zero slots counts as one
        drive_traffic(4);
        set_config(13'd8191, 16'd65535);
        drive_traffic(4);
        set_config(13'd4096, 16'd0);               // zero timeout
        drive_traffic(4);
        send_op(OP_UPDATE, 2'd0, snap_ms_m[0]);
        set_config(13'd1, 16'd1);
        drive_traffic(4);
    endtask

    task automatic test_saturation();
        logic [DATA_W-1:0] t0;
        t0 = $urandom;
        set_config(13'd1, 16'd1);
        send_op(OP_UPDATE, 2'd0, t0);
        repeat (285) send_op(OP_PULSE, 2'd2, $urandom);
        send_op(OP_UPDATE, 2'd0, t0 + 1'b1);
        send_op(OP_READ, 2'd2, '0);
    endtask

    task automatic test_backpressure();
        set_config(13'd20, 16'd500);
        hold_req = 1'b1;
        repeat (3) begin
            send_op(OP_READ, CH_W'($urandom), $urandom);
            send_op(OP_PULSE, CH_W'($urandom), $urandom);
            send_op(OP_UPDATE, 2'd0, snap_ms_m[0] + $urandom_range(1, 100));
        end
    endtask

    task automatic test_random();
        logic [SLOTS_W-1:0] slots;
        logic [TMO_W-1:0]   tmo;
        repeat (2) begin
            slots = $urandom_range(0, 1) ? SLOTS_W'($urandom_range(1, 64)) : SLOTS_W'($urandom);
            tmo   = $urandom_range(0, 1) ? TMO_W'($urandom_range(20, 600)) : TMO_W'($urandom);
            set_config(slots, tmo);
            drive_traffic(10);
        end
    endtask

    task automatic test_quiet_tail();
        quiet = 1'b1;
        drive_traffic(8);
    endtask

    task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (want !== got) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : reading_check
        t_reading want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (readings_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: unexpected transfer: ch %0d total %0h rpm %0h last %0b",
                             $time, res_if.result_channel, res_if.pulse_total,
                             res_if.rpm_q8, res_if.last);
            end else begin
                want = readings_q.pop_front();
                check_field("result_channel", want.ch, res_if.result_channel);
                check_field("pulse_total", want.total, res_if.pulse_total);
                check_field("rpm_q8", want.rpm, res_if.rpm_q8);
                check_field("last", want.last, res_if.last);
            end
        end
    end

    // result side pacing; a requested hold stalls the block for a long stretch
    initial begin : sink_pace
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
        end
    end

    initial begin : watchdog
        #8_000_000;
        $display("** multi_channel_pulse_tachometer: FAILED **");
        $finish;
    end

    initial begin : run
        int guard;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_SLOTS;
        i_cfg_data    <= '0;
        in_if.valid   <= 1'b0;
        in_if.op      <= OP_PULSE;
        in_if.channel <= '0;
        in_if.now_ms  <= '0;
        slots_m = SLOTS_RST;
        tmo_m   = TMO_RST;
        for (int i = 0; i < CHANNELS_DEF; i++) begin
            count_m[i]    = '0;
            snap_cnt_m[i] = '0;
            snap_ms_m[i]  = '0;
            rpm_m[i]      = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_directed_ops();
        test_register_extremes();
        test_saturation();
        test_backpressure();
        test_random();
        test_quiet_tail();

        in_if.valid <= 1'b0;
        guard = 0;
        while (readings_q.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && readings_q.size() == 0)
            $display("** multi_channel_pulse_tachometer: PASSED **");
        else
            $display("** multi_channel_pulse_tachometer: FAILED **");
        $finish;
    end

endmodule

[sim.f]
sv/mcpt_pkg.sv
sv/mcpt_in_if.sv
sv/mcpt_out_if.sv
sv/mcpt_div.sv
sv/multi_channel_pulse_tachometer.sv
tb/tb.sv
